FILE: design/bfsf_pkg.sv
// Shared constants, opcodes and result type for the bitmap free slot finder.
package bfsf_pkg;

  // Bitmap geometry (MAX_BITS is a power of two)
  localparam int MAX_BITS  = 8192;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = MAX_BITS / WORD_BITS;
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int POS_W     = $clog2(MAX_BITS);
  localparam int CNT_W     = POS_W + 1;
  localparam int WCNT_W    = ADDR_W + 1;

  // Request operations
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TEST  = 2'd2,
    OP_FIND  = 2'd3
  } op_t;

  // One result item
  typedef struct packed {
    logic             bit_value;
    logic             found;
    logic [POS_W-1:0] found_position;
    logic             range_error;
  } res_t;

endpackage

FILE: design/bfsf_in_if.sv
// Request channel: valid/ready handshake carrying opcode and position.
interface bfsf_in_if;
  logic                       valid;
  logic                       ready;
  bfsf_pkg::op_t              opcode;
  logic [bfsf_pkg::POS_W-1:0] position;

  modport source (output valid, output opcode, output position, input ready);
  modport sink   (input valid, input opcode, input position, output ready);
endinterface

FILE: design/bfsf_out_if.sv
// Result channel: valid/ready handshake carrying one result item.
interface bfsf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       bit_value;
  logic                       found;
  logic [bfsf_pkg::POS_W-1:0] found_position;
  logic                       range_error;

  modport source (output valid, output bit_value, output found, output found_position,
                  output range_error, input ready);
  modport sink   (input valid, input bit_value, input found, input found_position,
                  input range_error, output ready);
endinterface

FILE: design/bitmap_free_slot_finder.sv
// Occupancy bitmap with set/clear/test and circular find-first-free search.
//
// The bitmap (8192 positions) lives in one 128 x 64-bit synchronous RAM. After reset
// the block runs a clearing pass, one word per cycle, and accepts no request until
// it is done; bits_in_use writes are taken at any time. A request is handled one at
// a time: set, clear and test go from transfer to the next transfer through the
// steps read word, modify/write back, load output register; a position at or beyond
// bits_in_use skips the modify/write back step. A find reads one RAM word per cycle,
// starting at the word of the start position and wrapping at ceil(bits_in_use/64)
// words, coming back to the start word once for the bits below the start; the number
// of further words read after the start word is at most ceil(bits_in_use/64). The
// single RAM read port sets the pace of the scan. The result sits in an output
// register, so a new request is taken while a result still waits on the output side.
module bitmap_free_slot_finder (
  input  logic                       clk,
  input  logic                       rst_n,
  bfsf_in_if.sink                    in_chan,
  bfsf_out_if.source                 out_chan,
  input  logic                       cfg_wr_en,
  input  logic [bfsf_pkg::CNT_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_RESP
  } state_t;

  localparam int WB = bfsf_pkg::WORD_BITS;

  state_t                          state_r, state_nxt;
  logic [bfsf_pkg::ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  bfsf_pkg::op_t                   op_r, op_nxt;
  logic [bfsf_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [bfsf_pkg::ADDR_W-1:0]     word_r, word_nxt;
  logic [bfsf_pkg::WCNT_W-1:0]     scan_k_r, scan_k_nxt;
  bfsf_pkg::res_t                  res_r, res_nxt;
  bfsf_pkg::res_t                  out_res_r, out_res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [bfsf_pkg::CNT_W-1:0]      cfg_bits_r;

  // RAM signals
  logic [WB-1:0]                   mem [bfsf_pkg::MAP_WORDS];
  logic [WB-1:0]                   rd_data_r;
  logic                            mem_we;
  logic [bfsf_pkg::ADDR_W-1:0]     mem_waddr;
  logic [WB-1:0]                   mem_wdata;
  logic [bfsf_pkg::ADDR_W-1:0]     mem_raddr;

  // Active geometry
  logic [bfsf_pkg::CNT_W-1:0]      n_active;
  logic [bfsf_pkg::CNT_W-1:0]      n_round;
  logic [bfsf_pkg::WCNT_W-1:0]     n_words;
  logic [bfsf_pkg::ADDR_W-1:0]     last_word;
  logic [bfsf_pkg::OFF_W-1:0]      tail_lim;

  // Word evaluation
  logic [bfsf_pkg::OFF_W-1:0]      off;
  logic [WB-1:0]                   ge_mask;
  logic [WB-1:0]                   scan_mask;
  logic [WB-1:0]                   cand;
  logic [WB-1:0]                   cand_low;
  logic [bfsf_pkg::OFF_W-1:0]      ffs_idx;
  logic [bfsf_pkg::ADDR_W-1:0]     next_word;
  logic                            in_xfer;

  // Clamp the configured count into 1..MAX_BITS and derive the word span
  always_comb begin
    if (cfg_bits_r == '0) begin
      n_active = bfsf_pkg::CNT_W'(1);
    end else if (cfg_bits_r > bfsf_pkg::CNT_W'(bfsf_pkg::MAX_BITS)) begin
      n_active = bfsf_pkg::CNT_W'(bfsf_pkg::MAX_BITS);
    end else begin
      n_active = cfg_bits_r;
    end
    n_round   = n_active + bfsf_pkg::CNT_W'(WB - 1);
    n_words   = n_round[bfsf_pkg::CNT_W-1:bfsf_pkg::OFF_W];
    last_word = bfsf_pkg::ADDR_W'(n_words - bfsf_pkg::WCNT_W'(1));
    tail_lim  = n_active[bfsf_pkg::OFF_W-1:0];
  end

  // Search mask for the current word: start word split around the start bit,
  // last word trimmed to the count in use
  always_comb begin
    off     = pos_r[bfsf_pkg::OFF_W-1:0];
    ge_mask = {WB{1'b1}} << off;
    if (scan_k_r == '0) begin
      scan_mask = ge_mask;
    end else if (scan_k_r == n_words) begin
      scan_mask = ~ge_mask;
    end else begin
      scan_mask = {WB{1'b1}};
    end
    if (word_r == last_word && tail_lim != '0) begin
      scan_mask = scan_mask & ~({WB{1'b1}} << tail_lim);
    end
    cand     = ~rd_data_r & scan_mask;
    cand_low = cand & (~cand + WB'(1));
  end

  // Encode the isolated lowest free bit
  always_comb begin
    ffs_idx = '0;
    for (int i = 0; i < WB; i++) begin
      if (cand_low[i]) begin
        ffs_idx = ffs_idx | bfsf_pkg::OFF_W'(i);
      end
    end
  end

  assign next_word = (word_r == last_word) ? '0 : word_r + bfsf_pkg::ADDR_W'(1);
  assign in_xfer   = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  // Sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    scan_k_nxt    = scan_k_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = word_r;
    mem_wdata     = rd_data_r;
    mem_raddr     = in_chan.position[bfsf_pkg::OFF_W +: bfsf_pkg::ADDR_W];

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + bfsf_pkg::ADDR_W'(1);
        if (clr_addr_r == bfsf_pkg::ADDR_W'(bfsf_pkg::MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt     = in_chan.opcode;
          pos_nxt    = in_chan.position;
          word_nxt   = in_chan.position[bfsf_pkg::OFF_W +: bfsf_pkg::ADDR_W];
          scan_k_nxt = '0;
          res_nxt    = '0;
          if ({1'b0, in_chan.position} >= n_active) begin
            res_nxt.range_error = 1'b1;
            state_nxt           = S_RESP;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        case (op_r)
          bfsf_pkg::OP_SET: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_r | (WB'(1) << off);
            state_nxt = S_RESP;
          end
          bfsf_pkg::OP_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_r & ~(WB'(1) << off);
            state_nxt = S_RESP;
          end
          bfsf_pkg::OP_TEST: begin
            res_nxt.bit_value = rd_data_r[off];
            state_nxt         = S_RESP;
          end
          default: begin
            if (cand != '0) begin
              res_nxt.found          = 1'b1;
              res_nxt.found_position = {word_r, ffs_idx};
              state_nxt              = S_RESP;
            end else if (scan_k_r == n_words) begin
              state_nxt = S_RESP;
            end else begin
              // fetch the next word of the circular scan
              mem_raddr  = next_word;
              word_nxt   = next_word;
              scan_k_nxt = scan_k_r + bfsf_pkg::WCNT_W'(1);
            end
          end
        endcase
      end
      S_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // State, control and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      cfg_bits_r  <= bfsf_pkg::CNT_W'(bfsf_pkg::MAX_BITS);
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_bits_r <= cfg_wr_data;
      end
    end
    op_r      <= op_nxt;
    pos_r     <= pos_nxt;
    word_r    <= word_nxt;
    scan_k_r  <= scan_k_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  // Bitmap RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.bit_value      = out_res_r.bit_value;
  assign out_chan.found          = out_res_r.found;
  assign out_chan.found_position = out_res_r.found_position;
  assign out_chan.range_error    = out_res_r.range_error;

  // An error result carries nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.range_error |->
      !out_res_r.found && !out_res_r.bit_value && out_res_r.found_position == '0)
    else $error("range error result has other fields set");

  // A found position lies inside the active range
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.found |-> {1'b0, out_res_r.found_position} < n_active)
    else $error("found position beyond bits in use");

  // The scan never reads more than one lap plus the start word
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> scan_k_r <= n_words)
    else $error("scan count past one lap");

  // RAM writes only during the clearing pass or a set/clear write-back
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == S_CLEAR ||
      (state_r == S_EVAL && (op_r == bfsf_pkg::OP_SET || op_r == bfsf_pkg::OP_CLEAR)))
    else $error("unexpected RAM write");

  // An in-range transfer starts a word evaluation in the next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && ({1'b0, in_chan.position} < n_active) |=> state_r == S_EVAL)
    else $error("accepted request did not start evaluation");

endmodule

FILE: tb/bitmap_free_slot_finder_tb.sv
// Self-checking testbench for the bitmap free slot finder: set/clear/test/find traffic.
`timescale 1ns / 100ps

module bitmap_free_slot_finder_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [bfsf_pkg::POS_W-1:0] TOP_POS =
    bfsf_pkg::POS_W'(bfsf_pkg::MAX_BITS - 1);
  localparam logic [bfsf_pkg::CNT_W-1:0] FULL_COUNT =
    bfsf_pkg::CNT_W'(bfsf_pkg::MAX_BITS);

  // Tracks the occupancy map and the results it should produce, in request order
  class slot_scoreboard;
    bit [bfsf_pkg::WORD_BITS-1:0] occ_words [bfsf_pkg::MAP_WORDS];
    bit [bfsf_pkg::CNT_W-1:0]     count_reg;
    bfsf_pkg::res_t               expected_q [$];
    int unsigned                  errors;

    function new();
      foreach (occ_words[w]) occ_words[w] = '0;
      count_reg = bfsf_pkg::CNT_W'(bfsf_pkg::MAX_BITS);
      errors    = 0;
    endfunction

    function void set_count(bit [bfsf_pkg::CNT_W-1:0] value);
      count_reg = value;
    endfunction

    // Effective number of positions: zero acts as one, clamp at MAX_BITS
    function int unsigned span();
      if (count_reg == 0) return 1;
      if (count_reg > bfsf_pkg::MAX_BITS) return bfsf_pkg::MAX_BITS;
      return count_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request to the map and queue its result
    function void note_request(bfsf_pkg::op_t op, logic [bfsf_pkg::POS_W-1:0] pos);
      bfsf_pkg::res_t r;
      int unsigned    n;
      int unsigned    p;
      int unsigned    k;
      r = '0;
      n = span();
      if (pos >= n) begin
        r.range_error = 1'b1;
      end else begin
        case (op)
          bfsf_pkg::OP_SET:
            occ_words[pos / bfsf_pkg::WORD_BITS][pos % bfsf_pkg::WORD_BITS] = 1'b1;
          bfsf_pkg::OP_CLEAR:
            occ_words[pos / bfsf_pkg::WORD_BITS][pos % bfsf_pkg::WORD_BITS] = 1'b0;
          bfsf_pkg::OP_TEST:
            r.bit_value = occ_words[pos / bfsf_pkg::WORD_BITS][pos % bfsf_pkg::WORD_BITS];
          bfsf_pkg::OP_FIND: begin
            // circular scan from pos, wrapping at the count in use
            p = pos;
            for (k = 0; k < n; k++) begin
              if (!occ_words[p / bfsf_pkg::WORD_BITS][p % bfsf_pkg::WORD_BITS]) begin
                r.found          = 1'b1;
                r.found_position = bfsf_pkg::POS_W'(p);
                break;
              end
              p++;
              if (p >= n) p = 0;
            end
          end
        endcase
      end
      expected_q.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(bfsf_pkg::res_t got);
      bfsf_pkg::res_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.bit_value !== want.bit_value) begin
        $error("bit_value: expected %0d, actual %0d", want.bit_value, got.bit_value);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0d, actual %0d",
               want.found_position, got.found_position);
        errors++;
      end
      if (got.range_error !== want.range_error) begin
        $error("range_error: expected %0d, actual %0d", want.range_error, got.range_error);
        errors++;
      end
    endfunction

    function void check_drained();
      if (expected_q.size() != 0) begin
        $error("%0d results never arrived", expected_q.size());
        errors += expected_q.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [bfsf_pkg::CNT_W-1:0] cfg_wr_data;

  bfsf_in_if  in_chan ();
  bfsf_out_if out_chan ();

  slot_scoreboard sb;
  bit          steady;       // phase with no idling on either side
  int unsigned quiet_cycles = 0;

  bitmap_free_slot_finder u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one request and wait for its transfer; entered and left at a falling edge
  task automatic push_request(bfsf_pkg::op_t op, logic [bfsf_pkg::POS_W-1:0] pos);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid    = 1'b1;
    in_chan.opcode   = op;
    in_chan.position = pos;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sb.note_request(op, pos);
    @(negedge clk);
  endtask

  // Register write, only once every outstanding result is back
  task automatic write_count(logic [bfsf_pkg::CNT_W-1:0] value);
    in_chan.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_count(value);
  endtask

  // Random traffic at the current count; set_bias tilts toward filling the map
  task automatic random_phase(int unsigned items, int unsigned set_bias);
    int unsigned   n;
    int unsigned   q;
    bfsf_pkg::op_t op;
    logic [bfsf_pkg::POS_W-1:0] pos;
    n = sb.span();
    steady = ($urandom_range(0, 3) == 0);
    repeat (items) begin
      q = $urandom_range(0, 99);
      if (q < set_bias) op = bfsf_pkg::OP_SET;
      else if (q < set_bias + 12) op = bfsf_pkg::OP_CLEAR;
      else if (q < set_bias + 30) op = bfsf_pkg::OP_TEST;
      else op = bfsf_pkg::OP_FIND;
      if (n < bfsf_pkg::MAX_BITS && $urandom_range(0, 99) < 8)
        pos = bfsf_pkg::POS_W'($urandom_range(n, bfsf_pkg::MAX_BITS - 1));
      else pos = bfsf_pkg::POS_W'($urandom_range(0, n - 1));
      push_request(op, pos);
    end
    in_chan.valid = 1'b0;
    steady = 1'b0;
  endtask

  // Result side: random back-pressure, check every result transfer
  initial begin : result_sink
    int unsigned    stall_left;
    bfsf_pkg::res_t got;
    stall_left     = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        got.bit_value      = out_chan.bit_value;
        got.found          = out_chan.found;
        got.found_position = out_chan.found_position;
        got.range_error    = out_chan.range_error;
        sb.check_result(got);
        stall_left = pick_gap();
      end
      @(negedge clk);
      out_chan.ready = (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Watchdog: no transfer on either channel for too long
  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    sb               = new();
    steady           = 1'b0;
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_chan.valid    = 1'b0;
    in_chan.opcode   = bfsf_pkg::OP_SET;
    in_chan.position = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty map, wrap at the top, extremes of position
    push_request(bfsf_pkg::OP_FIND, 0);
    push_request(bfsf_pkg::OP_FIND, TOP_POS);
    push_request(bfsf_pkg::OP_TEST, TOP_POS);
    push_request(bfsf_pkg::OP_SET, 0);
    push_request(bfsf_pkg::OP_SET, TOP_POS);
    push_request(bfsf_pkg::OP_TEST, 0);
    push_request(bfsf_pkg::OP_TEST, TOP_POS);
    push_request(bfsf_pkg::OP_FIND, TOP_POS);
    push_request(bfsf_pkg::OP_SET, 1);
    push_request(bfsf_pkg::OP_SET, 63);
    push_request(bfsf_pkg::OP_FIND, 0);
    push_request(bfsf_pkg::OP_CLEAR, 0);
    push_request(bfsf_pkg::OP_FIND, TOP_POS);
    push_request(bfsf_pkg::OP_SET, 64);
    push_request(bfsf_pkg::OP_TEST, 64);

    // Single position in use: full map, out-of-range on every opcode
    write_count(1);
    push_request(bfsf_pkg::OP_SET, 0);
    push_request(bfsf_pkg::OP_FIND, 0);
    push_request(bfsf_pkg::OP_TEST, 1);
    push_request(bfsf_pkg::OP_SET, TOP_POS);
    push_request(bfsf_pkg::OP_CLEAR, 5);
    push_request(bfsf_pkg::OP_FIND, 4000);

    // Grow back: bits above the old count kept their values
    write_count(FULL_COUNT);
    push_request(bfsf_pkg::OP_TEST, TOP_POS);
    push_request(bfsf_pkg::OP_FIND, 62);

    // Random phases over a spread of counts, word boundaries and extremes
    write_count(64);    random_phase(80, 45);
    write_count(65);    random_phase(60, 50);
    write_count('1);    random_phase(40, 30);
    write_count(1);     random_phase(25, 30);
    write_count(0);     random_phase(25, 30);
    write_count(37);    random_phase(80, 55);
    write_count(128);   random_phase(60, 50);
    write_count(129);   random_phase(50, 40);
    write_count(FULL_COUNT - 1'b1); random_phase(40, 30);
    write_count(200);   random_phase(70, 55);
    write_count(bfsf_pkg::CNT_W'($urandom_range(2, 300))); random_phase(60, 50);
    write_count(FULL_COUNT); random_phase(60, 25);

    // Let the last results drain, then settle
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
